// ===== hdl/mck_pkg.sv =====
`default_nettype none

package mck_pkg;

  localparam int unsigned CharWidth  = 8;
  localparam int unsigned WpmWidth   = 7;
  localparam int unsigned UnitsWidth = 3;
  localparam int unsigned MsWidth    = 13;
  localparam int unsigned CodeWidth  = 7;
  localparam int unsigned DitWidth   = 11;

  localparam logic [DitWidth-1:0] DitReset = DitWidth'(60);
  localparam logic [CharWidth-1:0] CaseFoldLimit = CharWidth'(96);
  localparam logic [CharWidth-1:0] CaseFoldOffset = CharWidth'(32);
  localparam logic [CharWidth-1:0] CharSpace = CharWidth'(32);

  typedef enum logic [2:0] {
    STEP_IDLE,
    STEP_CLASS,
    STEP_CHECK,
    STEP_MARK,
    STEP_GAP,
    STEP_SPACE,
    STEP_EMPTY
  } mck_step_e;

  typedef enum logic [1:0] {
    COND_ALWAYS,
    COND_SPACE,
    COND_EMPTY,
    COND_DONE
  } mck_cond_e;

  typedef enum logic [1:0] {
    UNITS_MARK,
    UNITS_GAP,
    UNITS_TWO,
    UNITS_FOUR
  } mck_units_e;

  typedef enum logic [1:0] {
    LAST_NO,
    LAST_YES,
    LAST_IF_DONE
  } mck_last_e;

  typedef struct packed {
    logic       wait_in;
    logic       emit;
    logic       shift;
    logic       key_down;
    mck_units_e units_sel;
    mck_last_e  last_sel;
    mck_cond_e  cond;
    mck_step_e  t_true;
    mck_step_e  t_false;
  } mck_ctl_t;

  function automatic mck_ctl_t mck_ucode(input mck_step_e step);
    mck_ctl_t w;
    w = '{wait_in: 1'b0, emit: 1'b0, shift: 1'b0, key_down: 1'b0,
          units_sel: UNITS_MARK, last_sel: LAST_NO, cond: COND_ALWAYS,
          t_true: STEP_IDLE, t_false: STEP_IDLE};
    unique case (step)
      STEP_IDLE: begin
        w.wait_in = 1'b1;
        w.t_true  = STEP_CLASS;
        w.t_false = STEP_CLASS;
      end
      STEP_CLASS: begin
        w.cond    = COND_SPACE;
        w.t_true  = STEP_SPACE;
        w.t_false = STEP_CHECK;
      end
      STEP_CHECK: begin
        w.cond    = COND_EMPTY;
        w.t_true  = STEP_EMPTY;
        w.t_false = STEP_MARK;
      end
      STEP_MARK: begin
        w.emit      = 1'b1;
        w.shift     = 1'b1;
        w.key_down  = 1'b1;
        w.units_sel = UNITS_MARK;
        w.t_true    = STEP_GAP;
        w.t_false   = STEP_GAP;
      end
      STEP_GAP: begin
        w.emit      = 1'b1;
        w.units_sel = UNITS_GAP;
        w.last_sel  = LAST_IF_DONE;
        w.cond      = COND_DONE;
        w.t_true    = STEP_IDLE;
        w.t_false   = STEP_MARK;
      end
      STEP_SPACE: begin
        w.emit      = 1'b1;
        w.units_sel = UNITS_FOUR;
        w.last_sel  = LAST_YES;
      end
      STEP_EMPTY: begin
        w.emit      = 1'b1;
        w.units_sel = UNITS_TWO;
        w.last_sel  = LAST_YES;
      end
      default: begin
        w.t_true  = STEP_IDLE;
        w.t_false = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

  // Position in the code table: bits from the low end, 1 is a dit, 0 a dah,
  // above a stop bit. Zero means no code.
  function automatic logic [CodeWidth-1:0] mck_code(input logic [CharWidth-1:0] ch);
    logic [CodeWidth-1:0] c;
    c = '0;
    case (ch)
      "T": c = CodeWidth'(2);
      "E": c = CodeWidth'(3);
      "M": c = CodeWidth'(4);
      "A": c = CodeWidth'(5);
      "N": c = CodeWidth'(6);
      "I": c = CodeWidth'(7);
      "O": c = CodeWidth'(8);
      "W": c = CodeWidth'(9);
      "K": c = CodeWidth'(10);
      "U": c = CodeWidth'(11);
      "G": c = CodeWidth'(12);
      "R": c = CodeWidth'(13);
      "D": c = CodeWidth'(14);
      "S": c = CodeWidth'(15);
      "J": c = CodeWidth'(17);
      "Y": c = CodeWidth'(18);
      "Q": c = CodeWidth'(20);
      "X": c = CodeWidth'(22);
      "V": c = CodeWidth'(23);
      "P": c = CodeWidth'(25);
      "C": c = CodeWidth'(26);
      "F": c = CodeWidth'(27);
      "Z": c = CodeWidth'(28);
      "L": c = CodeWidth'(29);
      "B": c = CodeWidth'(30);
      "H": c = CodeWidth'(31);
      "0": c = CodeWidth'(32);
      "1": c = CodeWidth'(33);
      "2": c = CodeWidth'(35);
      "3": c = CodeWidth'(39);
      "=": c = CodeWidth'(46);
      "4": c = CodeWidth'(47);
      "9": c = CodeWidth'(48);
      "/": c = CodeWidth'(54);
      "8": c = CodeWidth'(56);
      "7": c = CodeWidth'(60);
      "6": c = CodeWidth'(62);
      "5": c = CodeWidth'(63);
      ",": c = CodeWidth'(76);
      ".": c = CodeWidth'(85);
      "*": c = CodeWidth'(87);
      "-": c = CodeWidth'(94);
      "?": c = CodeWidth'(115);
      default: c = '0;
    endcase
    return c;
  endfunction

  // Dit period in ms, 1200 / wpm rounded down, zero taken as one.
  function automatic logic [DitWidth-1:0] mck_dit(input logic [WpmWidth-1:0] w);
    logic [DitWidth-1:0] d;
    d = '0;
    if (w >= WpmWidth'(121)) d = DitWidth'(9);
    else if (w >= WpmWidth'(110)) d = DitWidth'(10);
    else if (w >= WpmWidth'(101)) d = DitWidth'(11);
    else if (w >= WpmWidth'(93)) d = DitWidth'(12);
    else if (w >= WpmWidth'(86)) d = DitWidth'(13);
    else if (w >= WpmWidth'(81)) d = DitWidth'(14);
    else if (w >= WpmWidth'(76)) d = DitWidth'(15);
    else if (w >= WpmWidth'(71)) d = DitWidth'(16);
    else if (w >= WpmWidth'(67)) d = DitWidth'(17);
    else if (w >= WpmWidth'(64)) d = DitWidth'(18);
    else if (w >= WpmWidth'(61)) d = DitWidth'(19);
    else if (w >= WpmWidth'(58)) d = DitWidth'(20);
    else if (w >= WpmWidth'(55)) d = DitWidth'(21);
    else if (w >= WpmWidth'(53)) d = DitWidth'(22);
    else if (w >= WpmWidth'(51)) d = DitWidth'(23);
    else if (w >= WpmWidth'(49)) d = DitWidth'(24);
    else if (w >= WpmWidth'(47)) d = DitWidth'(25);
    else if (w >= WpmWidth'(45)) d = DitWidth'(26);
    else if (w >= WpmWidth'(43)) d = DitWidth'(27);
    else if (w >= WpmWidth'(42)) d = DitWidth'(28);
    else if (w >= WpmWidth'(41)) d = DitWidth'(29);
    else if (w >= WpmWidth'(39)) d = DitWidth'(30);
    else if (w >= WpmWidth'(38)) d = DitWidth'(31);
    else if (w >= WpmWidth'(37)) d = DitWidth'(32);
    else if (w >= WpmWidth'(36)) d = DitWidth'(33);
    else if (w >= WpmWidth'(35)) d = DitWidth'(34);
    else if (w >= WpmWidth'(34)) d = DitWidth'(35);
    else if (w >= WpmWidth'(33)) d = DitWidth'(36);
    else if (w >= WpmWidth'(32)) d = DitWidth'(37);
    else if (w >= WpmWidth'(31)) d = DitWidth'(38);
    else if (w >= WpmWidth'(30)) d = DitWidth'(40);
    else begin
      case (w)
        WpmWidth'(2):  d = DitWidth'(600);
        WpmWidth'(3):  d = DitWidth'(400);
        WpmWidth'(4):  d = DitWidth'(300);
        WpmWidth'(5):  d = DitWidth'(240);
        WpmWidth'(6):  d = DitWidth'(200);
        WpmWidth'(7):  d = DitWidth'(171);
        WpmWidth'(8):  d = DitWidth'(150);
        WpmWidth'(9):  d = DitWidth'(133);
        WpmWidth'(10): d = DitWidth'(120);
        WpmWidth'(11): d = DitWidth'(109);
        WpmWidth'(12): d = DitWidth'(100);
        WpmWidth'(13): d = DitWidth'(92);
        WpmWidth'(14): d = DitWidth'(85);
        WpmWidth'(15): d = DitWidth'(80);
        WpmWidth'(16): d = DitWidth'(75);
        WpmWidth'(17): d = DitWidth'(70);
        WpmWidth'(18): d = DitWidth'(66);
        WpmWidth'(19): d = DitWidth'(63);
        WpmWidth'(20): d = DitWidth'(60);
        WpmWidth'(21): d = DitWidth'(57);
        WpmWidth'(22): d = DitWidth'(54);
        WpmWidth'(23): d = DitWidth'(52);
        WpmWidth'(24): d = DitWidth'(50);
        WpmWidth'(25): d = DitWidth'(48);
        WpmWidth'(26): d = DitWidth'(46);
        WpmWidth'(27): d = DitWidth'(44);
        WpmWidth'(28): d = DitWidth'(42);
        WpmWidth'(29): d = DitWidth'(41);
        default:       d = DitWidth'(1200);
      endcase
    end
    return d;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/morse_character_keyer.sv =====
`default_nettype none

// Morse keyer for one text character per item. Each accepted character
// produces one to twelve segments (key-down or key-up, length in dit units
// and in ms), the last one flagged, with the final gap stretched to three
// units; a space gives one four-unit key-up and an unknown character one
// two-unit key-up. A small microcode table steps a shift register holding the
// code, one segment per cycle when the output is not stalled. A character is
// taken in the idle step, checked for a space and then for an empty code,
// and then steps through alternating mark and gap steps; a new character is
// taken only back in idle, once the last segment of the one before is issued.
// The speed register is written through its own channel, which is always
// ready; the dit period is looked up from it at the write.
module morse_character_keyer (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire  [mck_pkg::WpmWidth-1:0]        words_per_minute_i,
  input  wire                                 in_valid_i,
  output logic                                in_stall_o,
  input  wire  [mck_pkg::CharWidth-1:0]       text_char_i,
  output logic                                out_valid_o,
  input  wire                                 out_stall_i,
  output logic                                key_down_o,
  output logic [mck_pkg::UnitsWidth-1:0]      duration_units_o,
  output logic [mck_pkg::MsWidth-1:0]         duration_ms_o,
  output logic                                last_segment_o
);
  import mck_pkg::*;

  mck_step_e             step_q, step_d;
  mck_ctl_t              ctl;
  logic [CodeWidth-1:0]  code_q;
  logic                  space_q;
  logic [DitWidth-1:0]   dit_q;
  logic [CharWidth-1:0]  folded;
  logic                  in_acc;
  logic                  slot_free;
  logic                  hold;
  logic                  cond_hit;
  logic                  done;
  logic [UnitsWidth-1:0] units;
  logic                  last;
  logic [DitWidth+UnitsWidth-1:0] ms_full;

  logic                  out_valid_q;
  logic                  key_down_q;
  logic [UnitsWidth-1:0] units_q;
  logic [MsWidth-1:0]    ms_q;
  logic                  last_q;

  assign ctl         = mck_ucode(step_q);
  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = !ctl.wait_in;
  assign in_acc      = in_valid_i && ctl.wait_in;
  assign slot_free   = !out_valid_q || !out_stall_i;
  assign hold        = (ctl.wait_in && !in_acc) || (ctl.emit && !slot_free);
  assign done        = (code_q == CodeWidth'(1));
  assign folded      = (text_char_i > CaseFoldLimit) ? text_char_i - CaseFoldOffset
                                                     : text_char_i;

  always_comb begin
    unique case (ctl.cond)
      COND_ALWAYS: cond_hit = 1'b1;
      COND_SPACE:  cond_hit = space_q;
      COND_EMPTY:  cond_hit = (code_q <= CodeWidth'(1));
      COND_DONE:   cond_hit = done;
      default:     cond_hit = 1'b1;
    endcase
  end

  always_comb begin
    unique case (ctl.units_sel)
      UNITS_MARK: units = code_q[0] ? UnitsWidth'(1) : UnitsWidth'(3);
      UNITS_GAP:  units = done ? UnitsWidth'(3) : UnitsWidth'(1);
      UNITS_TWO:  units = UnitsWidth'(2);
      UNITS_FOUR: units = UnitsWidth'(4);
      default:    units = UnitsWidth'(1);
    endcase
  end

  always_comb begin
    unique case (ctl.last_sel)
      LAST_NO:      last = 1'b0;
      LAST_YES:     last = 1'b1;
      LAST_IF_DONE: last = done;
      default:      last = 1'b0;
    endcase
  end

  assign ms_full = (DitWidth+UnitsWidth)'(units) * (DitWidth+UnitsWidth)'(dit_q);
  assign step_d  = hold ? step_q : (cond_hit ? ctl.t_true : ctl.t_false);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= STEP_IDLE;
      dit_q       <= DitReset;
      out_valid_q <= 1'b0;
    end else begin
      step_q <= step_d;
      if (cfg_valid_i) begin
        dit_q <= mck_dit(words_per_minute_i);
      end
      if (ctl.emit && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      code_q  <= mck_code(folded);
      space_q <= (folded == CharSpace);
    end else if (ctl.shift && !hold) begin
      code_q <= code_q >> 1;
    end
    if (ctl.emit && slot_free) begin
      key_down_q <= ctl.key_down;
      units_q    <= units;
      ms_q       <= ms_full[MsWidth-1:0];
      last_q     <= last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign key_down_o       = key_down_q;
  assign duration_units_o = units_q;
  assign duration_ms_o    = ms_q;
  assign last_segment_o   = last_q;

endmodule

`default_nettype wire
